// ===== hdl/dcpid_pkg.sv =====
// Shared types and constants for the DC motor PID speed controller.
// Used by dcpid_mac and the top level; depends on nothing.
`default_nettype none

package dcpid_pkg;

  // Multiplier operands: PID gains sign-extended, duty gain zero-extended, to 33 bits; 17-bit signed digit
  localparam int A_W   = 33;
  localparam int DIG_W = 17;
  localparam int B_W   = 64;
  localparam int DIG_N = 4;
  // Accumulator wide enough for the three PID products plus headroom
  localparam int ACC_W = 100;

  // Control word from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic       load;   // overwrite accumulator with the preload value
    logic       step;   // issue one digit product
    logic [1:0] shift;  // digit position, product weighted by 2^(16*shift)
  } mac_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/dcpid_mac.sv =====
// Shared multiply-accumulate unit: 33x17 signed product, then shifted add.
// Depends on dcpid_pkg for widths and the control struct.
`default_nettype none

module dcpid_mac (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire dcpid_pkg::mac_ctl_t                  ctl,
  input  wire logic signed [dcpid_pkg::ACC_W-1:0]   load_val,
  input  wire logic signed [dcpid_pkg::A_W-1:0]     a_op,
  input  wire logic signed [dcpid_pkg::DIG_W-1:0]   digit,
  output logic signed      [dcpid_pkg::ACC_W-1:0]   acc
);

  localparam int P_W = dcpid_pkg::A_W + dcpid_pkg::DIG_W;

  logic signed [P_W-1:0]              prod_r;
  logic [1:0]                         sh_r;
  logic                               vld_r;
  logic signed [dcpid_pkg::ACC_W-1:0] acc_r;
  logic signed [dcpid_pkg::ACC_W-1:0] prod_ext;
  logic signed [dcpid_pkg::ACC_W-1:0] prod_sh;

  // Stage 1: digit product
  always_ff @(posedge clk) begin
    prod_r <= a_op * digit;
    sh_r   <= ctl.shift;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= ctl.step;
    end
  end

  // Place the product at its digit weight
  assign prod_ext = dcpid_pkg::ACC_W'(prod_r);

  always_comb begin
    case (sh_r)
      2'd0:    prod_sh = prod_ext;
      2'd1:    prod_sh = prod_ext <<< 16;
      2'd2:    prod_sh = prod_ext <<< 32;
      default: prod_sh = prod_ext <<< 48;
    endcase
  end

  // Stage 2: accumulate
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      acc_r <= load_val;
    end else if (vld_r) begin
      acc_r <= acc_r + prod_sh;
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

// ===== hdl/dc_motor_pid_speed_control_core.sv =====
// PID speed controller core: sequencer, controller state and output register.
// Depends on dcpid_pkg and instantiates dcpid_mac.
//
// Usage: one input transfer per control tick (target speed, encoder speed
// magnitude and direction) yields exactly one result transfer (duty
// magnitude, bridge direction, direction-change and saturation flags).
// The user writes gains and duty mapping through the cfg_ port while idle;
// the block does not enforce this. Indexes beyond the register list are ignored.
// All multiplies go through one 33x17 multiply-accumulate unit: 12 digit
// products for the three PID terms and 4 for the duty mapping, with a
// pipeline drain after each pass, a scaling step between them and a finish
// state at the end. in_ready is high only when the sequencer is idle, so a
// new tick is accepted only once the previous one has left the finish state.
// If the receiver stalls, the result is held in the output register and
// the next tick is still accepted; its result waits in the finish state
// until the register is free.
// Reset (synchronous, active low) clears the gains, error sum, last error
// and drive direction (forward), and drops out_valid.
`default_nettype none

module dc_motor_pid_speed_control_core #(
  parameter int FRAC_BITS = 16,
  parameter int SUM_WIDTH = 48
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration write port
  input  wire logic               cfg_wr_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_wdata,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_target_speed,
  input  wire logic [30:0]        in_measured_speed,
  input  wire logic [1:0]         in_measured_direction,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [15:0]             out_duty_magnitude,
  output logic                    out_bridge_direction,
  output logic                    out_direction_changed,
  output logic                    out_duty_saturated
);

  localparam int ACC_W      = dcpid_pkg::ACC_W;
  localparam int DUTY_SHIFT = FRAC_BITS + 16;

  // Register indexes
  localparam logic [2:0] REG_KP   = 3'd0;
  localparam logic [2:0] REG_KI   = 3'd1;
  localparam logic [2:0] REG_KD   = 3'd2;
  localparam logic [2:0] REG_GAIN = 3'd3;
  localparam logic [2:0] REG_MIN  = 3'd4;

  // Operand selects (upper bits of the step counter)
  localparam logic [1:0] OP_KP   = 2'd0;
  localparam logic [1:0] OP_KI   = 2'd1;
  localparam logic [1:0] OP_KD   = 2'd2;
  localparam logic [1:0] OP_DUTY = 2'd3;

  localparam logic [1:0] DIR_BACKWARD = 2'd1;

  localparam logic [3:0] CNT_PID_LAST  = 4'd11;
  localparam logic [3:0] CNT_DUTY_BASE = 4'd12;
  localparam logic [3:0] CNT_DUTY_LAST = 4'd15;

  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
  localparam logic signed [63:0]          PID_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0]          PID_MIN = {1'b1, {63{1'b0}}};

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_PREP   = 8'b0000_0010,
    ST_MUL    = 8'b0000_0100,
    ST_DRAIN  = 8'b0000_1000,
    ST_SCALE  = 8'b0001_0000,
    ST_MUL2   = 8'b0010_0000,
    ST_DRAIN2 = 8'b0100_0000,
    ST_FINISH = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;

  // Configuration registers
  logic signed [31:0] kp_r, ki_r, kd_r;
  logic [31:0]        gain_r;
  logic [15:0]        min_duty_r;

  // Controller state
  logic signed [SUM_WIDTH-1:0] sum_r;
  logic signed [32:0]          last_err_r;
  logic                        dir_r;

  // Per-tick working registers
  logic signed [32:0] err_r;
  logic signed [33:0] diff_r;
  logic signed [63:0] pid_r;
  logic               cur_pos_r, cur_neg_r;
  logic               sum_sat_r;

  // Output register
  logic        out_valid_r;
  logic [15:0] out_duty_r;
  logic        out_dir_r, out_chg_r, out_sat_r;

  logic in_xfer, fin_go;

  dcpid_pkg::mac_ctl_t                mac_ctl;
  logic signed [ACC_W-1:0]            mac_load;
  logic signed [dcpid_pkg::A_W-1:0]   a_op;
  logic signed [dcpid_pkg::DIG_W-1:0] digit;
  logic signed [ACC_W-1:0]            acc;
  logic signed [dcpid_pkg::B_W-1:0]   b_op;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign fin_go   = (state_r == ST_FINISH) && (!out_valid_r || out_ready);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r       <= '0;
      ki_r       <= '0;
      kd_r       <= '0;
      gain_r     <= '0;
      min_duty_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_KP:   kp_r       <= cfg_wdata;
        REG_KI:   ki_r       <= cfg_wdata;
        REG_KD:   kd_r       <= cfg_wdata;
        REG_GAIN: gain_r     <= cfg_wdata;
        REG_MIN:  min_duty_r <= cfg_wdata[15:0];
        default:  ;
      endcase
    end
  end

  // Signed current speed and error at the input transfer
  logic signed [33:0] cur_w, err_w;

  always_comb begin
    if (in_measured_direction == DIR_BACKWARD) begin
      cur_w = -$signed(34'(in_measured_speed));
    end else begin
      cur_w = $signed(34'(in_measured_speed));
    end
    err_w = 34'(in_target_speed) - cur_w;
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      err_r     <= err_w[32:0];
      cur_pos_r <= (in_measured_speed != '0) && (in_measured_direction != DIR_BACKWARD);
      cur_neg_r <= (in_measured_speed != '0) && (in_measured_direction == DIR_BACKWARD);
    end
  end

  // Saturating error sum and derivative difference
  logic signed [SUM_WIDTH:0] sum_ext;
  logic                      sum_ovf_pos, sum_ovf_neg;

  assign sum_ext     = (SUM_WIDTH+1)'(sum_r) + (SUM_WIDTH+1)'(err_r);
  assign sum_ovf_pos = !sum_ext[SUM_WIDTH] && sum_ext[SUM_WIDTH-1];
  assign sum_ovf_neg = sum_ext[SUM_WIDTH] && !sum_ext[SUM_WIDTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r      <= '0;
      last_err_r <= '0;
    end else if (state_r == ST_PREP) begin
      if (sum_ovf_pos) begin
        sum_r <= SUM_MAX;
      end else if (sum_ovf_neg) begin
        sum_r <= SUM_MIN;
      end else begin
        sum_r <= sum_ext[SUM_WIDTH-1:0];
      end
      last_err_r <= err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_PREP) begin
      diff_r    <= 34'(err_r) - 34'(last_err_r);
      sum_sat_r <= sum_ovf_pos || sum_ovf_neg;
    end
  end

  // PID result: floor shift by the fraction bits, clipped to 64 signed bits
  logic signed [ACC_W-1:0]  pid_shr;
  logic [ACC_W-64:0]        pid_hi;
  logic signed [63:0]       pid_w;

  assign pid_shr = acc >>> FRAC_BITS;
  assign pid_hi  = pid_shr[ACC_W-1:63];

  always_comb begin
    if ((&pid_hi) || !(|pid_hi)) begin
      pid_w = pid_shr[63:0];
    end else if (pid_hi[ACC_W-64]) begin
      pid_w = PID_MIN;
    end else begin
      pid_w = PID_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SCALE) begin
      pid_r <= pid_w;
    end
  end

  // Operand selection for the shared unit
  always_comb begin
    case (cnt_r[3:2])
      OP_KP: begin
        a_op = 33'(kp_r);
        b_op = 64'(err_r);
      end
      OP_KI: begin
        a_op = 33'(ki_r);
        b_op = 64'(sum_r);
      end
      OP_KD: begin
        a_op = 33'(kd_r);
        b_op = 64'(diff_r);
      end
      default: begin
        a_op = $signed({1'b0, gain_r});
        b_op = pid_r;
      end
    endcase
  end

  // Low digits unsigned, top digit carries the sign
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    digit = $signed({1'b0, b_op[15:0]});
      2'd1:    digit = $signed({1'b0, b_op[31:16]});
      2'd2:    digit = $signed({1'b0, b_op[47:32]});
      default: digit = $signed({b_op[63], b_op[63:48]});
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    mac_ctl.load  = 1'b0;
    mac_ctl.step  = 1'b0;
    mac_ctl.shift = cnt_r[1:0];
    // the duty offset is preloaded at its weight so the final shift adds it
    mac_load      = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        mac_ctl.load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_MUL;
      end
      ST_MUL: begin
        mac_ctl.step = 1'b1;
        cnt_nxt      = cnt_r + 4'd1;
        if (cnt_r == CNT_PID_LAST) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        mac_ctl.load = 1'b1;
        mac_load     = ACC_W'(min_duty_r) <<< DUTY_SHIFT;
        cnt_nxt      = CNT_DUTY_BASE;
        state_nxt    = ST_MUL2;
      end
      ST_MUL2: begin
        mac_ctl.step = 1'b1;
        cnt_nxt      = cnt_r + 4'd1;
        if (cnt_r == CNT_DUTY_LAST) begin
          state_nxt = ST_DRAIN2;
        end
      end
      ST_DRAIN2: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (fin_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  dcpid_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mac_ctl),
    .load_val (mac_load),
    .a_op     (a_op),
    .digit    (digit),
    .acc      (acc)
  );

  // Duty: floor shift, sign, magnitude and saturation
  logic signed [ACC_W-1:0] duty_w;
  logic [ACC_W-1:0]        duty_mag;
  logic                    duty_neg, duty_zero, duty_clip, dir_nxt;

  assign duty_w    = acc >>> DUTY_SHIFT;
  assign duty_neg  = duty_w[ACC_W-1];
  assign duty_zero = (duty_w == '0);
  assign duty_mag  = duty_neg ? -duty_w : duty_w;
  assign duty_clip = |duty_mag[ACC_W-1:16];

  always_comb begin
    dir_nxt = dir_r;
    if (duty_neg && cur_pos_r) begin
      dir_nxt = 1'b1;
    end else if (!duty_neg && !duty_zero && cur_neg_r) begin
      dir_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= 1'b0;
    end else if (fin_go) begin
      dir_r <= dir_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_duty_r <= duty_clip ? 16'hFFFF : duty_mag[15:0];
      out_dir_r  <= dir_nxt;
      out_chg_r  <= dir_nxt != dir_r;
      out_sat_r  <= duty_clip || sum_sat_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_duty_magnitude    = out_duty_r;
  assign out_bridge_direction  = out_dir_r;
  assign out_direction_changed = out_chg_r;
  assign out_duty_saturated    = out_sat_r;

endmodule

`default_nettype wire

// ===== hdl/dcpid_checker.sv =====
// Port-level checks for the PID speed controller core, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module dcpid_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_duty_magnitude,
  input wire logic        out_bridge_direction,
  input wire logic        out_direction_changed,
  input wire logic        out_duty_saturated
);

  // Drive direction as last seen on a result transfer
  logic last_dir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_dir_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      last_dir_r <= out_bridge_direction;
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_duty_magnitude) &&
      $stable(out_bridge_direction) && $stable(out_direction_changed) &&
      $stable(out_duty_saturated))
    else $error("result changed while stalled");

  // Reset drops the result
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A tick occupies the sequencer: no back-to-back input transfers
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a tick is in progress");

  // Change flag matches the direction step between successive results
  a_dir_chg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |->
      out_direction_changed == (out_bridge_direction != last_dir_r))
    else $error("direction change flag inconsistent");

endmodule

bind dc_motor_pid_speed_control_core dcpid_checker u_dcpid_checker (.*);

`default_nettype wire
